// ===== src/priority_wait_queue_with_cancel_core_macros.svh =====
// ----------------------------------------------------------------------------
// Priority wait queue with cancel: assertion macros
// Clocked checks on clk, switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_WAIT_QUEUE_WITH_CANCEL_CORE_MACROS_SVH
`define PRIORITY_WAIT_QUEUE_WITH_CANCEL_CORE_MACROS_SVH

// Same-cycle implication
`define PWQC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define PWQC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pwqc_pkg.sv =====
// ----------------------------------------------------------------------------
// pwqc_pkg
// Command and result types, function codes and memory control for the
// priority wait queue with cancel.
// ----------------------------------------------------------------------------
`default_nettype none

package pwqc_pkg;

  // Function codes
  localparam logic [2:0] FN_CLEAR  = 3'd0;
  localparam logic [2:0] FN_PUSH   = 3'd1;
  localparam logic [2:0] FN_POP    = 3'd2;
  localparam logic [2:0] FN_CHECK  = 3'd3;
  localparam logic [2:0] FN_CANCEL = 3'd4;

  // Command payload
  typedef struct packed {
    logic [2:0] func;
    logic [1:0] priority_req;
    logic [3:0] block_id;
  } cmd_t;

  // Result payload
  typedef struct packed {
    logic       ok;
    logic [3:0] slot_out;
    logic       any_waiting;
  } rsp_t;

  // Link memory controls
  typedef struct packed {
    logic rd_en;
    logic next_we;
    logic prev_we;
    logic lvl_we;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== src/pwqc_links.sv =====
// ----------------------------------------------------------------------------
// pwqc_links
// Per-slot link store: next link, previous link and level of each slot.
// One shared read address with registered read data, one write port each.
// ----------------------------------------------------------------------------
`default_nettype none

module pwqc_links
  import pwqc_pkg::*;
#(
  parameter int SLOTS  = 16,
  parameter int LEVELS = 4
) (
  input  wire logic                        clk,
  input  wire mem_ctl_t                    ctl,
  input  wire logic [$clog2(SLOTS)-1:0]    raddr,
  input  wire logic [$clog2(SLOTS)-1:0]    next_waddr,
  input  wire logic [$clog2(SLOTS)-1:0]    next_wdata,
  input  wire logic [$clog2(SLOTS)-1:0]    prev_waddr,
  input  wire logic [$clog2(SLOTS)-1:0]    prev_wdata,
  input  wire logic [$clog2(SLOTS)-1:0]    lvl_waddr,
  input  wire logic [$clog2(LEVELS)-1:0]   lvl_wdata,
  output logic      [$clog2(SLOTS)-1:0]    next_rdata,
  output logic      [$clog2(SLOTS)-1:0]    prev_rdata,
  output logic      [$clog2(LEVELS)-1:0]   lvl_rdata
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(LEVELS);

  logic [SW-1:0] next_mem [SLOTS];
  logic [SW-1:0] prev_mem [SLOTS];
  logic [LW-1:0] lvl_mem  [SLOTS];

  // Writes
  always_ff @(posedge clk) begin
    if (ctl.next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (ctl.prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (ctl.lvl_we) begin
      lvl_mem[lvl_waddr] <= lvl_wdata;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      next_rdata <= next_mem[raddr];
      prev_rdata <= prev_mem[raddr];
      lvl_rdata  <= lvl_mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/priority_wait_queue_with_cancel_core.sv =====
// The accepted command and its link reads are registered; the result is
// registered when its update state completes. No new command is taken while
//   the link memory read and the update and write-back are under way.
// A stalled result holds the next command in its update cycle.
// Reset clears level and slot-queued flags at once; no clearing pass.
// ----------------------------------------------------------------------------
// priority_wait_queue_with_cancel_core
// Four-level FIFO wait lists of slot numbers kept as doubly linked lists,
// with push, pop of most urgent level, check, cancel and clear.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_wait_queue_with_cancel_core_macros.svh"

module priority_wait_queue_with_cancel_core
  import pwqc_pkg::*;
#(
  parameter int LEVELS = 4,
  parameter int SLOTS  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(LEVELS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t st, st_next;

  cmd_t          cmd_q;
  logic [SW-1:0] head [LEVELS];
  logic [SW-1:0] tail [LEVELS];
  logic [LEVELS-1:0] nonempty, nonempty_next;
  logic [SLOTS-1:0]  queued, queued_next;

  logic          accept;
  logic          exec_go;
  mem_ctl_t      mctl;
  logic [SW-1:0] rd_addr;
  logic [SW-1:0] next_waddr, next_wdata, prev_waddr, prev_wdata;
  logic [SW-1:0] next_rd, prev_rd;
  logic [LW-1:0] lvl_rd;

  logic          pop_found;
  logic [LW-1:0] pop_lvl;
  logic [LW-1:0] push_lvl;
  logic [LW-1:0] lvl_sel;
  logic [SW-1:0] head_sel, tail_sel;
  logic [SW-1:0] s_q;
  logic          s_in_range;
  logic          s_queued;

  logic          head_we, tail_we;
  logic [SW-1:0] head_wd, tail_wd;
  logic          res_ok;
  logic [SW-1:0] res_slot;

  // Handshake
  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (st != ST_IDLE);
  assign exec_go   = (st == ST_EXEC) && !(rsp_valid && rsp_stall);

  // Most urgent non-empty level
  always_comb begin
    pop_found = 1'b0;
    pop_lvl   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        pop_found = 1'b1;
        pop_lvl   = LW'(i);
      end
    end
  end

  // Decoded fields of the held command
  assign s_q        = SW'(cmd_q.block_id);
  assign s_in_range = (32'(cmd_q.block_id) < SLOTS);
  assign s_queued   = s_in_range && queued[s_q];
  assign push_lvl   = (32'(cmd_q.priority_req) >= LEVELS) ? LW'(LEVELS - 1)
                                                          : LW'(cmd_q.priority_req);

  // One level selected per cycle for head/tail access
  always_comb begin
    if (st == ST_IDLE) begin
      lvl_sel = pop_lvl;
    end else begin
      case (cmd_q.func)
        FN_PUSH: lvl_sel = push_lvl;
        FN_POP:  lvl_sel = pop_lvl;
        default: lvl_sel = lvl_rd;
      endcase
    end
  end

  assign head_sel = head[lvl_sel];
  assign tail_sel = tail[lvl_sel];

  // Link read address: pop reads the head slot, cancel reads its own slot
  assign rd_addr = (cmd.func == FN_POP) ? head_sel : SW'(cmd.block_id);

  // Update cycle: modify lists and links
  always_comb begin
    nonempty_next = nonempty;
    queued_next   = queued;
    head_we       = 1'b0;
    tail_we       = 1'b0;
    head_wd       = s_q;
    tail_wd       = s_q;
    mctl          = '0;
    mctl.rd_en    = accept;
    next_waddr    = tail_sel;
    next_wdata    = s_q;
    prev_waddr    = s_q;
    prev_wdata    = tail_sel;
    res_ok        = 1'b0;
    res_slot      = '0;
    if (exec_go) begin
      case (cmd_q.func)
        FN_CLEAR: begin
          nonempty_next = '0;
          queued_next   = '0;
          res_ok        = 1'b1;
        end
        FN_PUSH: begin
          if (s_in_range && !s_queued) begin
            if (nonempty[push_lvl]) begin
              mctl.next_we = 1'b1;
              mctl.prev_we = 1'b1;
            end else begin
              head_we                 = 1'b1;
              nonempty_next[push_lvl] = 1'b1;
            end
            tail_we          = 1'b1;
            mctl.lvl_we      = 1'b1;
            queued_next[s_q] = 1'b1;
            res_ok           = 1'b1;
          end
        end
        FN_POP: begin
          if (pop_found) begin
            if (head_sel == tail_sel) begin
              nonempty_next[pop_lvl] = 1'b0;
            end else begin
              head_we = 1'b1;
              head_wd = next_rd;
            end
            queued_next[head_sel] = 1'b0;
            res_ok                = 1'b1;
            res_slot              = head_sel;
          end
        end
        FN_CHECK: begin
          res_ok = |nonempty;
        end
        FN_CANCEL: begin
          if (s_queued) begin
            if ((head_sel == s_q) && (tail_sel == s_q)) begin
              nonempty_next[lvl_rd] = 1'b0;
            end else if (head_sel == s_q) begin
              head_we = 1'b1;
              head_wd = next_rd;
            end else if (tail_sel == s_q) begin
              tail_we = 1'b1;
              tail_wd = prev_rd;
            end else begin
              // unlink from the middle
              mctl.next_we = 1'b1;
              mctl.prev_we = 1'b1;
              next_waddr   = prev_rd;
              next_wdata   = next_rd;
              prev_waddr   = next_rd;
              prev_wdata   = prev_rd;
            end
            queued_next[s_q] = 1'b0;
            res_ok           = 1'b1;
          end
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (accept) begin
          st_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          st_next = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      nonempty  <= '0;
      queued    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      st       <= st_next;
      nonempty <= nonempty_next;
      queued   <= queued_next;
      if (exec_go) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (head_we) begin
      head[lvl_sel] <= head_wd;
    end
    if (tail_we) begin
      tail[lvl_sel] <= tail_wd;
    end
    if (exec_go) begin
      rsp.ok          <= res_ok;
      rsp.slot_out    <= 4'(res_slot);
      rsp.any_waiting <= |nonempty_next;
    end
  end

  // Link store
  pwqc_links #(
    .SLOTS  (SLOTS),
    .LEVELS (LEVELS)
  ) u_links (
    .clk        (clk),
    .ctl        (mctl),
    .raddr      (rd_addr),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .lvl_waddr  (s_q),
    .lvl_wdata  (push_lvl),
    .next_rdata (next_rd),
    .prev_rdata (prev_rd),
    .lvl_rdata  (lvl_rd)
  );

  // Checks
  `PWQC_ASSERT_NEXT(a_accept_to_exec, accept, st == ST_EXEC, "command did not enter update cycle")
  `PWQC_ASSERT_NOW(a_rsp_after_exec, $rose(rsp_valid), $past(st) == ST_EXEC, "result without update cycle")
  `PWQC_ASSERT_NOW(a_waiting_flag, rsp_valid, rsp.any_waiting == (|nonempty), "any_waiting out of step with level flags")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: priority wait queue with cancel
// Runs a directed sequence and then a long random sequence of clear, push,
// pop, check, cancel and spare-code commands through the core, with random gaps on the
// command side and random stalls on the result side. Every result is checked
// field by field against a predictor that tracks the linked wait lists.
// ----------------------------------------------------------------------------

module tb_top;
  import pwqc_pkg::*;

  localparam int LEVEL_COUNT  = 4;
  localparam int SLOT_COUNT   = 16;
  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PERCENT = 9;

  // Function codes the core ignores
  localparam logic [2:0] FN_SPARE_LO  = 3'd5;
  localparam logic [2:0] FN_SPARE_MID = 3'd6;
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;

  // --------------------------------------------------------------------------
  // Wait list tracker: predicts each result and checks the core's output
  // --------------------------------------------------------------------------
  class queue_tracker;
    logic [3:0] head_of [LEVEL_COUNT];
    logic [3:0] tail_of [LEVEL_COUNT];
    bit         level_busy [LEVEL_COUNT];
    logic [3:0] next_of [SLOT_COUNT];
    logic [3:0] prev_of [SLOT_COUNT];
    logic [1:0] level_of [SLOT_COUNT];
    bit         queued [SLOT_COUNT];
    rsp_t       pending_results [$];
    int         mismatches;

    function new();
      foreach (level_busy[i]) level_busy[i] = 1'b0;
      foreach (queued[i]) queued[i] = 1'b0;
      mismatches = 0;
    endfunction

    function bit any_busy();
      bit busy;
      busy = 1'b0;
      foreach (level_busy[i]) busy |= level_busy[i];
      return busy;
    endfunction

    // Apply one command to the tracked lists and return its result
    function rsp_t predict(cmd_t c);
      rsp_t       r;
      logic [3:0] s;
      logic [3:0] h;
      logic [3:0] p;
      logic [3:0] n;
      logic [1:0] lv;
      bit         found;
      r     = '0;
      s     = c.block_id;
      found = 1'b0;
      case (c.func)
        FN_CLEAR: begin
          foreach (level_busy[i]) level_busy[i] = 1'b0;
          foreach (queued[i]) queued[i] = 1'b0;
          r.ok = 1'b1;
        end
        FN_PUSH: begin
          lv = c.priority_req;
          // a slot already waiting is refused
          if (!queued[s]) begin
            if (level_busy[lv]) begin
              next_of[tail_of[lv]] = s;
              prev_of[s] = tail_of[lv];
            end else begin
              head_of[lv] = s;
              level_busy[lv] = 1'b1;
            end
            tail_of[lv] = s;
            level_of[s] = lv;
            queued[s] = 1'b1;
            r.ok = 1'b1;
          end
        end
        FN_POP: begin
          // head of the most urgent non-empty level
          for (int i = 0; i < LEVEL_COUNT; i++) begin
            if (!found && level_busy[i]) begin
              found = 1'b1;
              h = head_of[i];
              if (h == tail_of[i]) level_busy[i] = 1'b0;
              else head_of[i] = next_of[h];
              queued[h] = 1'b0;
              r.ok = 1'b1;
              r.slot_out = h;
            end
          end
        end
        FN_CHECK: r.ok = any_busy();
        FN_CANCEL: begin
          if (queued[s]) begin
            lv = level_of[s];
            if (head_of[lv] == s && tail_of[lv] == s) begin
              level_busy[lv] = 1'b0;
            end else if (head_of[lv] == s) begin
              head_of[lv] = next_of[s];
            end else if (tail_of[lv] == s) begin
              tail_of[lv] = prev_of[s];
            end else begin
              // unlink from the middle
              p = prev_of[s];
              n = next_of[s];
              next_of[p] = n;
              prev_of[n] = p;
            end
            queued[s] = 1'b0;
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      r.any_waiting = any_busy();
      return r;
    endfunction

    function void note_command(cmd_t c);
      pending_results.push_back(predict(c));
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %p with nothing pending", got));
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok)
          report_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
        if (got.slot_out !== want.slot_out)
          report_mismatch($sformatf("slot_out got %0d want %0d",
                                    got.slot_out, want.slot_out));
        if (got.any_waiting !== want.any_waiting)
          report_mismatch($sformatf("any_waiting got %b want %b",
                                    got.any_waiting, want.any_waiting));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals and core
  // --------------------------------------------------------------------------
  logic clk;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  cmd_t cmd       = '0;
  logic rsp_stall = 1'b0;
  logic cmd_stall;
  logic rsp_valid;
  rsp_t rsp;
  bit   calm      = 1'b0;

  queue_tracker sb = new();

  priority_wait_queue_with_cancel_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop on a hang
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top NOT OK");
    $finish;
  end

  // Result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall == 1'b0) sb.check_result(rsp);
    rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  // --------------------------------------------------------------------------
  // Command side
  // --------------------------------------------------------------------------
  function cmd_t make_cmd(logic [2:0] func, logic [1:0] lv, logic [3:0] slot);
    cmd_t c;
    c.func         = func;
    c.priority_req = lv;
    c.block_id     = slot;
    return c;
  endfunction

  // Random slot whose queued flag matches; any slot when none does
  function logic [3:0] pick_slot(bit want_queued);
    logic [3:0] cands [$];
    for (int i = 0; i < SLOT_COUNT; i++)
      if (sb.queued[i] == want_queued) cands.push_back(4'(i));
    if (cands.size() == 0) return 4'($urandom_range(0, SLOT_COUNT - 1));
    return cands[$urandom_range(0, cands.size() - 1)];
  endfunction

  // One command transfer, after an optional random gap
  task send_command(cmd_t c);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall !== 1'b0);
    sb.note_command(c);
  endtask

  initial begin
    cmd_t c;
    int   roll;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cases, duplicates, cancel at head, middle, tail, alone
    send_command(make_cmd(FN_CLEAR,  2'd0, 4'd0));
    send_command(make_cmd(FN_POP,    2'd3, 4'd15));
    send_command(make_cmd(FN_CHECK,  2'd0, 4'd0));
    send_command(make_cmd(FN_CANCEL, 2'd0, 4'd5));
    send_command(make_cmd(FN_PUSH,   2'd0, 4'd0));
    send_command(make_cmd(FN_PUSH,   2'd3, 4'd15));
    send_command(make_cmd(FN_PUSH,   2'd0, 4'd0));
    send_command(make_cmd(FN_PUSH,   2'd0, 4'd7));
    send_command(make_cmd(FN_PUSH,   2'd0, 4'd9));
    send_command(make_cmd(FN_CHECK,  2'd3, 4'd15));
    send_command(make_cmd(FN_CANCEL, 2'd0, 4'd7));
    send_command(make_cmd(FN_CANCEL, 2'd0, 4'd7));
    send_command(make_cmd(FN_CANCEL, 2'd3, 4'd0));
    send_command(make_cmd(FN_PUSH,   2'd0, 4'd3));
    send_command(make_cmd(FN_CANCEL, 2'd0, 4'd3));
    send_command(make_cmd(FN_CANCEL, 2'd0, 4'd9));
    send_command(make_cmd(FN_PUSH,   2'd2, 4'd4));
    send_command(make_cmd(FN_POP,    2'd0, 4'd0));
    send_command(make_cmd(FN_POP,    2'd0, 4'd0));
    send_command(make_cmd(FN_POP,    2'd0, 4'd0));
    send_command(make_cmd(FN_SPARE_LO,  2'd1, 4'd10));
    send_command(make_cmd(FN_SPARE_MID, 2'd2, 4'd11));
    send_command(make_cmd(FN_SPARE_HI,  2'd3, 4'd12));
    send_command(make_cmd(FN_PUSH,   2'd1, 4'd10));
    send_command(make_cmd(FN_CLEAR,  2'd3, 4'd15));
    send_command(make_cmd(FN_CANCEL, 2'd1, 4'd10));

    // Random: mostly push, pop and cancel on live slots, some noise
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm <= (k >= 700 && k < 1000);
      roll = $urandom_range(0, 99);
      c.func         = FN_CHECK;
      c.priority_req = 2'($urandom_range(0, LEVEL_COUNT - 1));
      c.block_id     = 4'($urandom_range(0, SLOT_COUNT - 1));
      if (roll < 2) begin
        c.func = FN_CLEAR;
      end else if (roll < 5) begin
        c.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
      end else if (roll < 10) begin
        c.func = FN_CHECK;
      end else if (roll < 48) begin
        c.func     = FN_PUSH;
        c.block_id = pick_slot($urandom_range(0, 99) < 25);
      end else if (roll < 75) begin
        c.func = FN_POP;
      end else begin
        c.func     = FN_CANCEL;
        c.block_id = pick_slot($urandom_range(0, 99) < 70);
      end
      send_command(c);
    end
    cmd_valid <= 1'b0;
    calm      <= 1'b0;

    // Drain, then wait quietly for any stray result
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
